// ===== hdl/oah_pkg.sv =====
package oah_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 34;
    localparam int FUNC_W     = 2;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [FUNC_W-1:0] func_t;

    // operation codes
    localparam func_t FUNC_INSERT = 2'd0;
    localparam func_t FUNC_READ   = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    // quadratic probe offset i*i, reduced mod TABLE_SIZE
    function automatic slot_t sq_offset(input slot_t i);
        logic [2*SLOT_W-1:0] prod;
        prod = {{SLOT_W{1'b0}}, i} * {{SLOT_W{1'b0}}, i};
        return prod[SLOT_W-1:0];
    endfunction

endpackage

// ===== hdl/open_addressing_hash_insert.sv =====
// Open-addressing hash table, 16 slots of 34-bit keys. Pulse start while busy
// is low to issue one item: insert (func 0), read slot (func 1) or clear
// (func 2). Every item returns exactly one result, shown for a single cycle
// with done high; the receiver cannot stall it, so capture it on that edge.
// Insert hashes to key mod 16 and walks the probe sequence (linear or
// quadratic per probe_mode) one slot per cycle against the valid flops,
// registering the result at the first free slot; a full table reports
// table_full after all 16 probes. Read goes through the key RAM (synchronous
// read) into rdata_reg and then the result registers. Clear drops all valid
// bits at once and answers the next cycle. busy falls in the same cycle that
// done rises, so the next item may be issued while a result is shown. The
// user must write probe_mode by cfg_we / cfg_wdata only while the block is
// idle; the block does not enforce this. No clearing pass after reset.
module open_addressing_hash_insert (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  oah_pkg::func_t          func,
    input  oah_pkg::key_t           key,
    input  oah_pkg::slot_t          slot_index,
    output logic                    done,
    output oah_pkg::slot_t          slot,
    output oah_pkg::key_t           entry_key,
    output logic                    entry_used,
    output logic                    table_full,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata
);

    typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_READ} state_t;

    localparam oah_pkg::slot_t LAST_PROBE = oah_pkg::slot_t'(oah_pkg::TABLE_SIZE - 1);

    state_t                            state_reg;
    logic                              probe_mode_reg;
    logic [oah_pkg::TABLE_SIZE-1:0]    valid_reg;
    oah_pkg::key_t                     key_reg;
    oah_pkg::slot_t                    home_reg;
    oah_pkg::slot_t                    cnt_reg;
    oah_pkg::slot_t                    idx_reg;
    logic                              idx_valid_reg;

    // result registers
    logic                              done_reg;
    oah_pkg::slot_t                    slot_reg;
    oah_pkg::key_t                     entry_key_reg;
    logic                              entry_used_reg;
    logic                              table_full_reg;

    // key RAM
    oah_pkg::key_t                     key_mem [oah_pkg::TABLE_SIZE];
    oah_pkg::key_t                     rdata_reg;

    logic                              accept;
    oah_pkg::slot_t                    probe_addr;
    logic                              probe_hit;
    logic                              mem_we;

    assign accept = start && (state_reg == ST_IDLE);

    // probe position for step cnt_reg
    always_comb
    begin
        if (probe_mode_reg)
            probe_addr = home_reg + oah_pkg::sq_offset(cnt_reg);
        else
            probe_addr = home_reg + cnt_reg;
    end

    assign probe_hit = !valid_reg[probe_addr];
    assign mem_we    = (state_reg == ST_PROBE) && probe_hit;

    // synchronous RAM: write on a placed insert, read at the accepted index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            key_mem[probe_addr] <= key_reg;
        rdata_reg <= key_mem[slot_index];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            probe_mode_reg <= 1'b0;
            valid_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                probe_mode_reg <= cfg_wdata;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (func)
                            oah_pkg::FUNC_INSERT:
                            begin
                                state_reg <= ST_PROBE;
                            end
                            oah_pkg::FUNC_READ:
                            begin
                                state_reg <= ST_READ;
                            end
                            oah_pkg::FUNC_CLEAR:
                            begin
                                valid_reg      <= '0;
                                done_reg       <= 1'b1;
                                slot_reg       <= '0;
                                entry_key_reg  <= '0;
                                entry_used_reg <= 1'b0;
                                table_full_reg <= 1'b0;
                            end
                            default:
                            begin
                                done_reg       <= 1'b1;
                                slot_reg       <= '0;
                                entry_key_reg  <= '0;
                                entry_used_reg <= 1'b0;
                                table_full_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_PROBE:
                begin
                    if (probe_hit)
                    begin
                        valid_reg[probe_addr] <= 1'b1;
                        state_reg      <= ST_IDLE;
                        done_reg       <= 1'b1;
                        slot_reg       <= probe_addr;
                        entry_key_reg  <= key_reg;
                        entry_used_reg <= 1'b1;
                        table_full_reg <= 1'b0;
                    end
                    else if (cnt_reg == LAST_PROBE)
                    begin
                        state_reg      <= ST_IDLE;
                        done_reg       <= 1'b1;
                        slot_reg       <= '0;
                        entry_key_reg  <= '0;
                        entry_used_reg <= 1'b0;
                        table_full_reg <= 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg      <= ST_IDLE;
                    done_reg       <= 1'b1;
                    slot_reg       <= idx_reg;
                    entry_key_reg  <= idx_valid_reg ? rdata_reg : '0;
                    entry_used_reg <= idx_valid_reg;
                    table_full_reg <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg       <= key;
            home_reg      <= key[oah_pkg::SLOT_W-1:0];
            cnt_reg       <= '0;
            idx_reg       <= slot_index;
            idx_valid_reg <= valid_reg[slot_index];
        end
        else if (state_reg == ST_PROBE)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign slot       = slot_reg;
    assign entry_key  = entry_key_reg;
    assign entry_used = entry_used_reg;
    assign table_full = table_full_reg;

`ifndef NO_ASSERTIONS
    // in linear mode a full report only when every slot was occupied;
    // the quadratic orbit can miss empty slots
    a_full_means_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!probe_mode_reg && state_reg == ST_PROBE && !probe_hit && cnt_reg == LAST_PROBE)
        |-> (&valid_reg))
        else $error("table_full raised with an empty slot");

    // a placed key marks its slot valid
    a_place_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(probe_addr)])
        else $error("placed slot not marked valid");

    // result flags never both set
    a_used_xor_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(entry_used && table_full))
        else $error("entry_used and table_full both set");

    // the block goes idle whenever a result is shown
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");
`endif

endmodule
